>>> rtl/core/heading_pid_differential_drive_core_macros.svh
// Assertion macros for the heading PID core checker.
// Used by heading_pid_differential_drive_core_chk; no other dependencies.
`ifndef HEADING_PID_DIFFERENTIAL_DRIVE_CORE_MACROS_SVH
`define HEADING_PID_DIFFERENTIAL_DRIVE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define HPDD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heading pid core: same-cycle check failed");

// next-cycle implication, disabled during reset
`define HPDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heading pid core: next-cycle check failed");

`endif

>>> rtl/core/hpdd_pkg.sv
// Shared types and constants for the heading PID differential-drive core.
// No dependencies; used by the core and its checker.
package hpdd_pkg;

   localparam int AccWidth = 52;   // product accumulator, holds the full PID sum
   localparam int MulBits  = 16;   // multiplier bits, one retired per cycle
   localparam int CntWidth = $clog2(MulBits);

   localparam logic signed [16:0] HalfTurn = 17'sd12861;
   localparam logic signed [16:0] FullTurn = 17'sd25723;
   localparam logic signed [13:0] UnitQ12  = 14'sd4096;

   localparam logic signed [AccWidth-1:0] RoundQ12 = AccWidth'(2048);
   localparam logic signed [AccWidth-1:0] RoundQ8  = AccWidth'(128);

   // register map
   typedef enum logic [2:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_STEP_SECONDS = 3'd3,
      CSR_STEP_RATE    = 3'd4,
      CSR_SPEED_LIMIT  = 3'd5
   } csr_index_type;

   localparam logic [15:0] PropGainReset    = 16'd4096;
   localparam logic [15:0] IntegGainReset   = 16'd2048;
   localparam logic [15:0] DerivGainReset   = 16'd819;
   localparam logic [11:0] StepSecondsReset = 12'd262;
   localparam logic [15:0] StepRateReset    = 16'd4000;
   localparam logic [14:0] SpeedLimitReset  = 15'd16384;

   // multiply passes through the shared serial multiplier, in order
   typedef enum logic [2:0] {
      OP_INC   = 3'd0,
      OP_DER   = 3'd1,
      OP_PROP  = 3'd2,
      OP_INTEG = 3'd3,
      OP_DERIV = 3'd4,
      OP_LEFT  = 3'd5,
      OP_RIGHT = 3'd6
   } op_type;

endpackage

>>> rtl/core/heading_pid_differential_drive_core.sv
// Heading PID controller with differential-drive wheel outputs, Q4.12.
// Depends on hpdd_pkg.
//
// Usage:
//   req_*  : one transfer per control tick carrying measured and target heading.
//   rsp_*  : one transfer per tick with left/right wheel speed and correction.
//   csr_*  : register writes (index, data); csr_ready is always high. Write
//            only while the core is idle and no response is outstanding.
// All arithmetic runs through one shift-add multiplier that retires one
// multiplier bit per cycle. A tick uses seven 16-bit passes (integral step,
// derivative, three PID terms, two wheel speeds), each pass running through
// a load step, the multiply steps and a post-processing step.
// req_stall is high while a tick is being computed. A finished response sits
// in the output register; the next tick is accepted while it waits, and that
// tick holds in its last step until the older response is taken.
// Reset (synchronous) restores register defaults and clears the integral and
// the previous error.
module heading_pid_differential_drive_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [14:0] req_measured_heading,
   input  logic signed [14:0] req_target_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [14:0] rsp_left_wheel,
   output logic        [14:0] rsp_right_wheel,
   output logic signed [13:0] rsp_correction,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic         [2:0] csr_index,
   input  logic        [15:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_POST = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   hpdd_pkg::op_type op_ff, op_in;
   logic [hpdd_pkg::CntWidth-1:0] cnt_ff, cnt_in;

   logic signed [hpdd_pkg::AccWidth-1:0] acc_ff, acc_in;
   logic signed [hpdd_pkg::AccWidth-1:0] mcand_ff, mcand_in;
   logic [hpdd_pkg::MulBits-1:0] mplier_ff, mplier_in;

   logic [15:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff, step_rate_ff;
   logic [11:0] step_seconds_ff;
   logic [14:0] speed_limit_ff;

   logic signed [31:0] error_sum_ff, error_sum_in;
   logic signed [15:0] last_error_ff, last_error_in;
   logic signed [15:0] err_ff, err_in;
   logic signed [16:0] diff_ff, diff_in;
   logic signed [25:0] der_ff, der_in;
   logic signed [13:0] corr_ff, corr_in;
   logic [14:0] left_ff, left_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [14:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic signed [13:0] rsp_corr_ff, rsp_corr_in;

   logic req_xfer, rsp_xfer;
   logic signed [16:0] raw_err, wrap_err;
   logic signed [hpdd_pkg::AccWidth-1:0] rnd12, rnd8, lim_ext, wheel;
   logic signed [16:0] inc;
   logic signed [32:0] sum_wide;
   logic signed [15:0] corr_wide;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_wheel  = rsp_left_ff;
   assign rsp_right_wheel = rsp_right_ff;
   assign rsp_correction  = rsp_corr_ff;

   // heading error, wrapped once
   always_comb begin
      raw_err = 17'(req_target_heading) - 17'(req_measured_heading);
      if (raw_err > hpdd_pkg::HalfTurn) begin
         wrap_err = raw_err - hpdd_pkg::FullTurn;
      end else if (raw_err < -hpdd_pkg::HalfTurn) begin
         wrap_err = raw_err + hpdd_pkg::FullTurn;
      end else begin
         wrap_err = raw_err;
      end
   end

   // rounded views of the accumulator
   assign rnd12    = (acc_ff + hpdd_pkg::RoundQ12) >>> 12;
   assign rnd8     = (acc_ff + hpdd_pkg::RoundQ8) >>> 8;
   assign inc      = rnd12[16:0];
   assign sum_wide = 33'(error_sum_ff) + 33'(inc);
   assign lim_ext  = {{(hpdd_pkg::AccWidth-15){1'b0}}, speed_limit_ff};
   assign wheel    = (rnd12 > lim_ext) ? lim_ext : rnd12;
   assign corr_wide = 16'(corr_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      error_sum_in  = error_sum_ff;
      last_error_in = last_error_ff;
      err_in        = err_ff;
      diff_in       = diff_ff;
      der_in        = der_ff;
      corr_in       = corr_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_xfer;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_corr_in   = rsp_corr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               err_in   = wrap_err[15:0];
               diff_in  = wrap_err - 17'(last_error_ff);
               op_in    = hpdd_pkg::OP_INC;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in = '0;
            // PID terms sum into one accumulator
            if (op_ff != hpdd_pkg::OP_INTEG && op_ff != hpdd_pkg::OP_DERIV) begin
               acc_in = '0;
            end
            case (op_ff)
               hpdd_pkg::OP_INC: begin
                  mcand_in  = hpdd_pkg::AccWidth'(err_ff);
                  mplier_in = {4'b0, step_seconds_ff};
               end
               hpdd_pkg::OP_DER: begin
                  mcand_in  = hpdd_pkg::AccWidth'(diff_ff);
                  mplier_in = step_rate_ff;
               end
               hpdd_pkg::OP_PROP: begin
                  mcand_in  = hpdd_pkg::AccWidth'(err_ff);
                  mplier_in = prop_gain_ff;
               end
               hpdd_pkg::OP_INTEG: begin
                  mcand_in  = hpdd_pkg::AccWidth'(error_sum_ff);
                  mplier_in = integ_gain_ff;
               end
               hpdd_pkg::OP_DERIV: begin
                  mcand_in  = hpdd_pkg::AccWidth'(der_ff);
                  mplier_in = deriv_gain_ff;
               end
               hpdd_pkg::OP_LEFT: begin
                  mcand_in  = lim_ext;
                  mplier_in = 16'(hpdd_pkg::UnitQ12) - corr_wide;
               end
               default: begin
                  mcand_in  = lim_ext;
                  mplier_in = 16'(hpdd_pkg::UnitQ12) + corr_wide;
               end
            endcase
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == hpdd_pkg::CntWidth'(hpdd_pkg::MulBits - 1)) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            state_in = ST_LOAD;
            op_in    = hpdd_pkg::op_type'(op_ff + 3'd1);
            case (op_ff)
               hpdd_pkg::OP_INC: begin
                  // integral saturates at the signed 32-bit range
                  if (sum_wide[32] != sum_wide[31]) begin
                     error_sum_in = sum_wide[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
                  end else begin
                     error_sum_in = sum_wide[31:0];
                  end
               end
               hpdd_pkg::OP_DER: begin
                  der_in        = rnd8[25:0];
                  last_error_in = err_ff;
               end
               hpdd_pkg::OP_DERIV: begin
                  if (rnd12 > hpdd_pkg::AccWidth'(hpdd_pkg::UnitQ12)) begin
                     corr_in = hpdd_pkg::UnitQ12;
                  end else if (rnd12 < -hpdd_pkg::AccWidth'(hpdd_pkg::UnitQ12)) begin
                     corr_in = -hpdd_pkg::UnitQ12;
                  end else begin
                     corr_in = rnd12[13:0];
                  end
               end
               hpdd_pkg::OP_LEFT: begin
                  left_in = wheel[14:0];
               end
               hpdd_pkg::OP_RIGHT: begin
                  // hold here until the output register is free
                  if (rsp_valid_ff && rsp_stall) begin
                     state_in = ST_POST;
                     op_in    = op_ff;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_left_in  = left_ff;
                     rsp_right_in = wheel[14:0];
                     rsp_corr_in  = corr_ff;
                     state_in     = ST_IDLE;
                     op_in        = hpdd_pkg::OP_INC;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         op_ff           <= hpdd_pkg::OP_INC;
         rsp_valid_ff    <= 1'b0;
         error_sum_ff    <= '0;
         last_error_ff   <= '0;
         prop_gain_ff    <= hpdd_pkg::PropGainReset;
         integ_gain_ff   <= hpdd_pkg::IntegGainReset;
         deriv_gain_ff   <= hpdd_pkg::DerivGainReset;
         step_seconds_ff <= hpdd_pkg::StepSecondsReset;
         step_rate_ff    <= hpdd_pkg::StepRateReset;
         speed_limit_ff  <= hpdd_pkg::SpeedLimitReset;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               hpdd_pkg::CSR_PROP_GAIN:    prop_gain_ff    <= csr_wdata;
               hpdd_pkg::CSR_INTEG_GAIN:   integ_gain_ff   <= csr_wdata;
               hpdd_pkg::CSR_DERIV_GAIN:   deriv_gain_ff   <= csr_wdata;
               hpdd_pkg::CSR_STEP_SECONDS: step_seconds_ff <= csr_wdata[11:0];
               hpdd_pkg::CSR_STEP_RATE:    step_rate_ff    <= csr_wdata;
               hpdd_pkg::CSR_SPEED_LIMIT:  speed_limit_ff  <= csr_wdata[14:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      der_ff       <= der_in;
      corr_ff      <= corr_in;
      left_ff      <= left_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_corr_ff  <= rsp_corr_in;
   end

endmodule

>>> rtl/core/heading_pid_differential_drive_core_chk.sv
// Port-level checker for heading_pid_differential_drive_core, bound to it.
// Depends on hpdd_pkg and heading_pid_differential_drive_core_macros.svh.
`include "heading_pid_differential_drive_core_macros.svh"

module heading_pid_differential_drive_core_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [14:0] req_measured_heading,
   input logic signed [14:0] req_target_heading,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic        [14:0] rsp_left_wheel,
   input logic        [14:0] rsp_right_wheel,
   input logic signed [13:0] rsp_correction,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic         [2:0] csr_index,
   input logic        [15:0] csr_wdata
);

   logic req_xfer;
   logic corr_ok;

   assign req_xfer = req_valid && !req_stall;
   assign corr_ok  = (rsp_correction <= hpdd_pkg::UnitQ12)
                  && (rsp_correction >= -hpdd_pkg::UnitQ12);

   // a tick keeps the core busy after it is taken
   `HPDD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall)

   // a response only appears at the end of a busy period
   `HPDD_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // clamped correction, and steering toward the positive side slows the left wheel
   `HPDD_ASSERT_NOW(a_corr_range, clock, reset, rsp_valid, corr_ok)
   `HPDD_ASSERT_NOW(a_wheel_order, clock, reset, rsp_valid && !rsp_correction[13],
      rsp_left_wheel <= rsp_right_wheel)

   // held response does not change
   `HPDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_left_wheel) && $stable(rsp_right_wheel)
      && $stable(rsp_correction))

endmodule

bind heading_pid_differential_drive_core heading_pid_differential_drive_core_chk u_chk (.*);

>>> tb/hpdd_wheel_checker.sv
`timescale 1ns / 100ps
// Transfer monitor and predictor for the heading PID differential-drive core.
// Depends on hpdd_pkg; instantiated by heading_pid_differential_drive_core_tb.
module hpdd_wheel_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [14:0] req_measured_heading,
   input  logic signed [14:0] req_target_heading,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic        [14:0] rsp_left_wheel,
   input  logic        [14:0] rsp_right_wheel,
   input  logic signed [13:0] rsp_correction,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic         [2:0] csr_index,
   input  logic        [15:0] csr_wdata,
   output int                 error_count,
   output int                 outstanding
);

   typedef struct packed {
      logic        [14:0] left_spd;
      logic        [14:0] right_spd;
      logic signed [13:0] corr;
   } wheel_cmd_type;

   // register copies
   logic [15:0] kp, ki, kd, rate_q8;
   logic [11:0] period_q12;
   logic [14:0] speed_cap;

   // controller state
   int                 integral;
   logic signed [15:0] prev_err;

   wheel_cmd_type wheel_q[$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // round half up of v / 2^k
   function automatic longint round_q(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic wheel_cmd_type predict_wheels(input logic signed [14:0] meas,
                                                    input logic signed [14:0] targ);
      wheel_cmd_type cmd;
      longint err, sum, der, acc, c, lim, lft, rgt;
      err = longint'(targ) - longint'(meas);
      // single wrap only
      if (err > longint'(hpdd_pkg::HalfTurn))
         err = err - longint'(hpdd_pkg::FullTurn);
      else if (err < -longint'(hpdd_pkg::HalfTurn))
         err = err + longint'(hpdd_pkg::FullTurn);

      sum = longint'(integral) + round_q(err * longint'(period_q12), 12);
      if (sum > longint'(32'sh7FFF_FFFF))
         sum = longint'(32'sh7FFF_FFFF);
      if (sum < -longint'(32'sh7FFF_FFFF) - 1)
         sum = -longint'(32'sh7FFF_FFFF) - 1;
      integral = int'(sum);

      der = round_q((err - longint'(prev_err)) * longint'(rate_q8), 8);
      prev_err = 16'(err);

      acc = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * der;
      c = round_q(acc, 12);
      if (c > longint'(hpdd_pkg::UnitQ12))
         c = longint'(hpdd_pkg::UnitQ12);
      if (c < -longint'(hpdd_pkg::UnitQ12))
         c = -longint'(hpdd_pkg::UnitQ12);

      lim = longint'(speed_cap);
      lft = round_q(lim * (longint'(hpdd_pkg::UnitQ12) - c), 12);
      rgt = round_q(lim * (longint'(hpdd_pkg::UnitQ12) + c), 12);
      if (lft > lim) lft = lim;
      if (rgt > lim) rgt = lim;
      if (lft < 0) lft = 0;
      if (rgt < 0) rgt = 0;

      cmd.left_spd  = 15'(lft);
      cmd.right_spd = 15'(rgt);
      cmd.corr      = 14'(c);
      return cmd;
   endfunction

   task automatic check_field(input string what, input logic signed [15:0] exp_v,
                              input logic signed [15:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      wheel_cmd_type exp_cmd;
      if (reset) begin
         kp         = hpdd_pkg::PropGainReset;
         ki         = hpdd_pkg::IntegGainReset;
         kd         = hpdd_pkg::DerivGainReset;
         period_q12 = hpdd_pkg::StepSecondsReset;
         rate_q8    = hpdd_pkg::StepRateReset;
         speed_cap  = hpdd_pkg::SpeedLimitReset;
         integral   = 0;
         prev_err   = '0;
         wheel_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hpdd_pkg::CSR_PROP_GAIN:    kp         = csr_wdata;
               hpdd_pkg::CSR_INTEG_GAIN:   ki         = csr_wdata;
               hpdd_pkg::CSR_DERIV_GAIN:   kd         = csr_wdata;
               hpdd_pkg::CSR_STEP_SECONDS: period_q12 = csr_wdata[11:0];
               hpdd_pkg::CSR_STEP_RATE:    rate_q8    = csr_wdata;
               hpdd_pkg::CSR_SPEED_LIMIT:  speed_cap  = csr_wdata[14:0];
               default: ;  // unmapped index, dropped
            endcase
         end
         if (req_valid && !req_stall)
            wheel_q.push_back(predict_wheels(req_measured_heading, req_target_heading));
         if (rsp_valid && !rsp_stall) begin
            if (wheel_q.size() == 0) begin
               $display("%0t: wheel command transfer with none expected, actual %0d %0d %0d",
                        $time, rsp_left_wheel, rsp_right_wheel, rsp_correction);
               error_count++;
            end else begin
               exp_cmd = wheel_q.pop_front();
               check_field("left wheel", 16'(exp_cmd.left_spd), 16'(rsp_left_wheel));
               check_field("right wheel", 16'(exp_cmd.right_spd), 16'(rsp_right_wheel));
               check_field("correction", 16'($signed(exp_cmd.corr)),
                           16'($signed(rsp_correction)));
            end
         end
      end
      outstanding = wheel_q.size();
   end

endmodule

>>> tb/heading_pid_differential_drive_core_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the heading PID differential-drive core.
// Depends on hpdd_pkg, heading_pid_differential_drive_core and hpdd_wheel_checker.
module heading_pid_differential_drive_core_tb;

   localparam int CycleLimit = 1_500_000;
   localparam int HoldCycles = 600;
   localparam int DrainCycles = 150;
   localparam logic [2:0] FirstUnusedIndex = 3'(hpdd_pkg::CSR_SPEED_LIMIT) + 3'd1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [14:0] req_measured_heading = '0;
   logic signed [14:0] req_target_heading = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic        [14:0] rsp_left_wheel;
   logic        [14:0] rsp_right_wheel;
   logic signed [13:0] rsp_correction;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic         [2:0] csr_index = '0;
   logic        [15:0] csr_wdata = '0;

   int error_count;
   int outstanding;
   int issued = 0;
   int got = 0;
   int cycles = 0;
   bit calm = 1'b0;
   bit hold_rsp = 1'b0;

   heading_pid_differential_drive_core DUT (.*);

   hpdd_wheel_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (rsp_valid && !rsp_stall)
         got <= got + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_heading(input logic signed [14:0] meas, input logic signed [14:0] targ);
      req_valid <= 1'b1;
      req_measured_heading <= meas;
      req_target_heading <= targ;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      issued++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop offering and let every outstanding tick come back
   task automatic drain;
      req_valid <= 1'b0;
      while (issued != got) @(posedge clock);
   endtask

   task automatic load_gains(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                             input logic [15:0] per, input logic [15:0] rate,
                             input logic [15:0] lim);
      write_reg(hpdd_pkg::CSR_PROP_GAIN, p);
      write_reg(hpdd_pkg::CSR_INTEG_GAIN, i);
      write_reg(hpdd_pkg::CSR_DERIV_GAIN, d);
      write_reg(hpdd_pkg::CSR_STEP_SECONDS, per);
      write_reg(hpdd_pkg::CSR_STEP_RATE, rate);
      write_reg(hpdd_pkg::CSR_SPEED_LIMIT, lim);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [14:0] rand_heading();
      if ($urandom_range(0, 19) == 0)
         return 15'($urandom);  // beyond +/- pi now and then
      return 15'($signed($urandom_range(0, 25722)) - 12861);
   endfunction

   function automatic logic [15:0] rand_gain();
      if ($urandom_range(0, 1) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 8191));
   endfunction

   task automatic run_random(input int count);
      logic signed [14:0] m, t;
      for (int n = 0; n < count; n++) begin
         t = rand_heading();
         // mostly small tracking errors, so the integral and derivative build up
         if ($urandom_range(0, 2) == 0)
            m = rand_heading();
         else
            m = t + 15'($signed($urandom_range(0, 800)) - 400);
         send_heading(m, t);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset gains: wrap edges, full-width headings, correction clamp both ways
      send_heading(15'sd0, 15'sd0);
      send_heading(-15'sd12861, 15'sd12861);
      send_heading(15'sd12861, -15'sd12861);
      send_heading(15'sd0, 15'sd12861);
      send_heading(-15'sd1, 15'sd12861);
      send_heading(15'sd0, -15'sd12861);
      send_heading(15'sd1, -15'sd12861);
      send_heading(-15'sd16384, 15'sd16383);
      send_heading(15'sd16383, -15'sd16384);
      send_heading(15'sd16383, 15'sd16383);
      send_heading(-15'sd16384, -15'sd16384);
      send_heading(15'sd12861, 15'sd12861);
      send_heading(-15'sd12861, -15'sd12861);
      repeat (4) send_heading(15'sd0, 15'sd6000);
      repeat (4) send_heading(15'sd6000, 15'sd0);
      send_heading(15'sd12861, -15'sd1);
      send_heading(15'sd100, 15'sd100);
      run_random(150);
      drain();

      // everything zero; unmapped indexes must be dropped
      write_reg(FirstUnusedIndex, 16'($urandom));
      write_reg(FirstUnusedIndex + 3'd1, 16'($urandom));
      load_gains('0, '0, '0, '0, '0, '0);
      send_heading(-15'sd12861, 15'sd12861);
      run_random(60);
      drain();

      // everything at its top; period and limit see masked data
      load_gains('1, '1, '1, '1, '1, '1);
      send_heading(15'sd16383, -15'sd16384);
      run_random(100);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         load_gains(rand_gain(), rand_gain(), rand_gain(), 16'($urandom),
                    rand_gain(), 16'($urandom));
         if (ph == 0)
            hold_rsp = 1'b1;  // back up the core while items keep coming
         run_random(150);
         drain();
      end

      // final stretch, no idling on either side
      calm = 1'b1;
      load_gains(hpdd_pkg::PropGainReset, hpdd_pkg::IntegGainReset,
                 hpdd_pkg::DerivGainReset, 16'(hpdd_pkg::StepSecondsReset),
                 hpdd_pkg::StepRateReset, 16'(hpdd_pkg::SpeedLimitReset));
      run_random(150);
      drain();

      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
